/* rtl/wlf_pkg.sv */
package wlf_pkg;

  // track buffer depth, 3 to 16
  localparam int MAX_POINTS = 4;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // datapath width of the shared unit, holds every sum, product and numerator
  localparam int WIDE_W  = 160;
  // multiplier operand width (signed) scanned by the bit-serial multiply
  localparam int MUL_B_W = 64;
  // radicand width of the weight square root: size << 16
  localparam int ROOT_W  = 48;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FEW  = 2'd1;
  localparam logic [1:0] STAT_SING = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_ROOT
  } alu_op_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [WIDE_W-1:0] a;
    logic [WIDE_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [WIDE_W-1:0] res;
  } alu_rsp_t;

endpackage

/* rtl/wlf_if.sv */
interface wlf_pnt_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] size_x;
  logic [31:0] size_z;
  logic [31:0] error_x;
  logic [31:0] error_z;
  logic        last_point;

  modport source (output valid, pos_x, pos_y, pos_z, size_x, size_z, error_x, error_z,
                  last_point, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, size_x, size_z, error_x, error_z,
                  last_point, output ready);
endinterface

interface wlf_fit_if;
  logic        valid;
  logic        ready;
  logic [31:0] slope_xy;
  logic [31:0] intercept_xy;
  logic [31:0] chi_xy;
  logic [31:0] slope_zy;
  logic [31:0] intercept_zy;
  logic [31:0] chi_zy;
  logic [1:0]  fit_status;

  modport source (output valid, slope_xy, intercept_xy, chi_xy, slope_zy, intercept_zy,
                  chi_zy, fit_status, input ready);
  modport sink   (input valid, slope_xy, intercept_xy, chi_xy, slope_zy, intercept_zy,
                  chi_zy, fit_status, output ready);
endinterface

/* rtl/wlf_alu.sv */
module wlf_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wlf_pkg::alu_req_t req_i,
  output wlf_pkg::alu_rsp_t rsp_o
);

  localparam int W    = wlf_pkg::WIDE_W;
  localparam int MB   = wlf_pkg::MUL_B_W;
  localparam int RW   = wlf_pkg::ROOT_W;
  localparam int SC_W = $clog2(W + 1);

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_FIX
  } alu_state_e;

  alu_state_e       state_q;
  wlf_pkg::alu_op_e op_q;
  logic             neg_q;
  logic [SC_W-1:0]  cnt_q;
  logic [W:0]       acc_q;
  logic [W-1:0]     sh_q;
  logic [W-1:0]     dv_q;
  logic [W-1:0]     quo_q;
  logic [W-1:0]     res_q;
  logic             done_q;

  logic [W-1:0] a_mag, b_mag, fin;
  logic [W:0]   part, trial, mul_acc;
  logic [W+1:0] diff;
  logic         ge;

  assign a_mag = req_i.a[W-1] ? (~req_i.a + W'(1)) : req_i.a;
  assign b_mag = req_i.b[W-1] ? (~req_i.b + W'(1)) : req_i.b;

  // root brings down two radicand bits a step, divide one
  assign part  = (op_q == wlf_pkg::OP_ROOT) ? {acc_q[W-2:0], sh_q[W-1 -: 2]}
                                            : {acc_q[W-1:0], sh_q[W-1]};
  assign trial = (op_q == wlf_pkg::OP_ROOT) ? {quo_q[W-2:0], 2'b01} : {1'b0, dv_q};
  assign diff  = {1'b0, part} - {1'b0, trial};
  assign ge    = ~diff[W+1];

  assign mul_acc = {acc_q[W-1:0], 1'b0} + {1'b0, (sh_q[W-1] ? dv_q : {W{1'b0}})};
  assign fin     = (op_q == wlf_pkg::OP_MUL) ? acc_q[W-1:0] : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      op_q    <= wlf_pkg::OP_MUL;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      acc_q   <= '0;
      sh_q    <= '0;
      dv_q    <= '0;
      quo_q   <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            op_q    <= req_i.op;
            acc_q   <= '0;
            quo_q   <= '0;
            state_q <= A_RUN;
            unique case (req_i.op)
              wlf_pkg::OP_MUL: begin
                neg_q <= req_i.a[W-1] ^ req_i.b[W-1];
                dv_q  <= a_mag;
                sh_q  <= {b_mag[MB-1:0], {(W-MB){1'b0}}};
                cnt_q <= SC_W'(MB);
              end
              wlf_pkg::OP_DIV: begin
                neg_q <= req_i.a[W-1] ^ req_i.b[W-1];
                dv_q  <= b_mag;
                sh_q  <= a_mag;
                cnt_q <= SC_W'(W);
              end
              default: begin  // root
                neg_q <= 1'b0;
                dv_q  <= '0;
                sh_q  <= {req_i.a[RW-1:0], {(W-RW){1'b0}}};
                cnt_q <= SC_W'(RW / 2);
              end
            endcase
          end
        end
        A_RUN: begin
          cnt_q <= cnt_q - SC_W'(1);
          if (op_q == wlf_pkg::OP_MUL) begin
            acc_q <= mul_acc;
            sh_q  <= sh_q << 1;
          end else begin
            acc_q <= ge ? diff[W:0] : part;
            quo_q <= {quo_q[W-2:0], ge};
            sh_q  <= (op_q == wlf_pkg::OP_ROOT) ? (sh_q << 2) : (sh_q << 1);
          end
          if (cnt_q == SC_W'(1)) state_q <= A_FIX;
        end
        A_FIX: begin
          res_q   <= neg_q ? (~fin + W'(1)) : fin;
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* rtl/weighted_line_fit_chi2_core.sv */
// Weighted straight-line fit of x(y) and z(y) with reduced chi-square per track.
// pnt_i takes one hit per request; last_point closes the track. Up to MAX_POINTS
// hits are buffered, later ones are dropped but their mark still closes the track.
// fit_o carries one result per closed track: slopes, intercepts, chi-squares and
// fit_status (ok, fewer than three points, singular); non-ok results are all zero.
// Unmarked hits are taken back to back while idle. A closed track keeps pnt_i not
// ready while a single bit-serial wide unit does the work, one multiply, divide or
// square root at a time. A track of fewer than three points goes straight to the
// output register. A singular xy plane skips the zy plane.
// The result sits in an output register: when fit_o is stalled the block goes on
// taking hits of the next track and only waits if that track finishes first.
// Reset empties the point buffer and drops any pending result.
module weighted_line_fit_chi2_core (
  input logic       clk_i,
  input logic       rst_ni,
  wlf_pnt_if.sink   pnt_i,
  wlf_fit_if.source fit_o
);

  localparam int W  = wlf_pkg::WIDE_W;
  localparam int N  = wlf_pkg::MAX_POINTS;
  localparam int IW = wlf_pkg::IDX_W;
  localparam int CW = wlf_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE, S_ROOT, S_WY, S_TC, S_TY, S_WC, S_D1, S_D2, S_N1, S_N2, S_SLOPE,
    S_I1, S_I2, S_ICPT, S_RMUL, S_RSQ, S_RDIV, S_CHI, S_DONE
  } fit_state_e;

  function automatic logic [W-1:0] sx32(logic [31:0] v);
    return {{(W-32){v[31]}}, v};
  endfunction

  function automatic logic [31:0] sat_s32(logic [W-1:0] v);
    logic fits;
    fits = (&v[W-1:31]) | ~(|v[W-1:31]);
    if (fits) return v[31:0];
    return v[W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic [31:0] sat_u32(logic [W-1:0] v);
    return (|v[W-1:32]) ? 32'hffff_ffff : v[31:0];
  endfunction

  // point buffer
  logic [31:0] bx_q [N];
  logic [31:0] by_q [N];
  logic [31:0] bz_q [N];
  logic [31:0] bsx_q [N];
  logic [31:0] bsz_q [N];
  logic [31:0] bex_q [N];
  logic [31:0] bez_q [N];

  fit_state_e   state_q;
  logic [CW-1:0] cnt_q, m_q, cnt_nx;
  logic [IW-1:0] i_q;
  logic          plane_q, wait_q, out_valid_q;
  logic [1:0]    status_q;
  logic [W-1:0]  s0_q, sy_q, syy_q, sc_q, scy_q, t_q, d_q, num_q, sum_q, wv_q;
  logic [31:0]   slope_q [2];
  logic [31:0]   icpt_q [2];
  logic [31:0]   chi_q [2];
  logic [63:0]   r_q;
  logic [31:0]   o_sxy_q, o_ixy_q, o_cxy_q, o_szy_q, o_izy_q, o_czy_q;
  logic [1:0]    o_stat_q;

  wlf_pkg::alu_req_t alu_req;
  wlf_pkg::alu_rsp_t alu_rsp;

  logic          acc_in, full, last_i;
  logic [31:0]   c_sel, s_sel, e_sel, y_cur, e_fix;
  logic [W-1:0]  diff_tr;
  logic [63:0]   padj, pred, r_new;
  logic [W-1:0]  wv_new;

  assign acc_in = pnt_i.valid && pnt_i.ready;
  assign full   = cnt_q >= CW'(N);
  assign cnt_nx = full ? cnt_q : cnt_q + CW'(1);
  assign last_i = i_q == IW'(m_q - CW'(1));

  assign c_sel = plane_q ? bz_q[i_q] : bx_q[i_q];
  assign s_sel = plane_q ? bsz_q[i_q] : bsx_q[i_q];
  assign e_sel = plane_q ? bez_q[i_q] : bex_q[i_q];
  assign y_cur = by_q[i_q];
  assign e_fix = (e_sel == 32'd0) ? 32'd1 : e_sel;

  assign diff_tr = t_q - alu_rsp.res;
  assign wv_new  = {alu_rsp.res[W-2:0], 1'b0};

  // prediction truncates slope*y / 2^16 toward zero
  assign padj  = alu_rsp.res[63:0] + {48'h0, {16{alu_rsp.res[63]}}};
  assign pred  = {{16{padj[63]}}, padj[63:16]} + {{32{icpt_q[plane_q][31]}}, icpt_q[plane_q]};
  assign r_new = {{32{c_sel[31]}}, c_sel} - pred;

  always_comb begin
    alu_req.start = (state_q != S_IDLE) && (state_q != S_DONE) && !wait_q;
    alu_req.op    = wlf_pkg::OP_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (state_q)
      S_ROOT: begin
        alu_req.op = wlf_pkg::OP_ROOT;
        alu_req.a  = {{(W-48){1'b0}}, s_sel, 16'h0};
      end
      S_WY:  begin alu_req.a = wv_q;  alu_req.b = sx32(y_cur); end
      S_TC:  begin alu_req.a = t_q;   alu_req.b = sx32(c_sel); end
      S_TY:  begin alu_req.a = t_q;   alu_req.b = sx32(y_cur); end
      S_WC:  begin alu_req.a = wv_q;  alu_req.b = sx32(c_sel); end
      S_D1:  begin alu_req.a = syy_q; alu_req.b = s0_q; end
      S_D2:  begin alu_req.a = sy_q;  alu_req.b = sy_q; end
      S_N1:  begin alu_req.a = scy_q; alu_req.b = s0_q; end
      S_N2:  begin alu_req.a = sc_q;  alu_req.b = sy_q; end
      S_I1:  begin alu_req.a = syy_q; alu_req.b = sc_q; end
      S_I2:  begin alu_req.a = scy_q; alu_req.b = sy_q; end
      S_SLOPE, S_ICPT: begin
        alu_req.op = wlf_pkg::OP_DIV;
        alu_req.a  = num_q;
        alu_req.b  = d_q;
      end
      S_RMUL: begin
        alu_req.a = sx32(y_cur);
        alu_req.b = sx32(slope_q[plane_q]);
      end
      S_RSQ: begin
        alu_req.a = {{(W-64){r_q[63]}}, r_q};
        alu_req.b = {{(W-64){r_q[63]}}, r_q};
      end
      S_RDIV: begin
        alu_req.op = wlf_pkg::OP_DIV;
        alu_req.a  = t_q;
        alu_req.b  = {{(W-32){1'b0}}, e_fix};
      end
      S_CHI: begin
        alu_req.op = wlf_pkg::OP_DIV;
        alu_req.a  = sum_q;
        alu_req.b  = {{(W-CW){1'b0}}, m_q - CW'(2)};
      end
      default: ;
    endcase
  end

  wlf_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (acc_in && !full) begin
      bx_q[cnt_q[IW-1:0]]  <= pnt_i.pos_x;
      by_q[cnt_q[IW-1:0]]  <= pnt_i.pos_y;
      bz_q[cnt_q[IW-1:0]]  <= pnt_i.pos_z;
      bsx_q[cnt_q[IW-1:0]] <= pnt_i.size_x;
      bsz_q[cnt_q[IW-1:0]] <= pnt_i.size_z;
      bex_q[cnt_q[IW-1:0]] <= pnt_i.error_x;
      bez_q[cnt_q[IW-1:0]] <= pnt_i.error_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      m_q         <= '0;
      i_q         <= '0;
      plane_q     <= 1'b0;
      wait_q      <= 1'b0;
      status_q    <= wlf_pkg::STAT_OK;
      out_valid_q <= 1'b0;
      s0_q  <= '0; sy_q <= '0; syy_q <= '0; sc_q <= '0; scy_q <= '0;
      t_q   <= '0; d_q  <= '0; num_q <= '0; sum_q <= '0; wv_q <= '0;
      r_q   <= '0;
      slope_q[0] <= '0; slope_q[1] <= '0;
      icpt_q[0]  <= '0; icpt_q[1]  <= '0;
      chi_q[0]   <= '0; chi_q[1]   <= '0;
      o_sxy_q <= '0; o_ixy_q <= '0; o_cxy_q <= '0;
      o_szy_q <= '0; o_izy_q <= '0; o_czy_q <= '0;
      o_stat_q <= wlf_pkg::STAT_OK;
    end else begin
      if (out_valid_q && fit_o.ready) out_valid_q <= 1'b0;
      if (alu_req.start) wait_q <= 1'b1;
      if (alu_rsp.done) wait_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (acc_in) begin
            if (pnt_i.last_point) begin
              cnt_q <= '0;
              m_q   <= cnt_nx;
              if (cnt_nx < CW'(3)) begin
                status_q <= wlf_pkg::STAT_FEW;
                state_q  <= S_DONE;
              end else begin
                status_q <= wlf_pkg::STAT_OK;
                plane_q  <= 1'b0;
                i_q      <= '0;
                s0_q <= '0; sy_q <= '0; syy_q <= '0; sc_q <= '0; scy_q <= '0;
                state_q  <= S_ROOT;
              end
            end else begin
              cnt_q <= cnt_nx;
            end
          end
        end
        S_ROOT: if (alu_rsp.done) begin
          wv_q    <= wv_new;
          s0_q    <= s0_q + wv_new;
          state_q <= S_WY;
        end
        S_WY: if (alu_rsp.done) begin
          t_q     <= alu_rsp.res;
          sy_q    <= sy_q + alu_rsp.res;
          state_q <= S_TC;
        end
        S_TC: if (alu_rsp.done) begin
          scy_q   <= scy_q + alu_rsp.res;
          state_q <= S_TY;
        end
        S_TY: if (alu_rsp.done) begin
          syy_q   <= syy_q + alu_rsp.res;
          state_q <= S_WC;
        end
        S_WC: if (alu_rsp.done) begin
          sc_q <= sc_q + alu_rsp.res;
          if (last_i) begin
            i_q     <= '0;
            state_q <= S_D1;
          end else begin
            i_q     <= i_q + IW'(1);
            state_q <= S_ROOT;
          end
        end
        S_D1: if (alu_rsp.done) begin
          t_q     <= alu_rsp.res;
          state_q <= S_D2;
        end
        S_D2: if (alu_rsp.done) begin
          d_q <= diff_tr;
          if (diff_tr == '0) begin
            status_q <= wlf_pkg::STAT_SING;
            state_q  <= S_DONE;
          end else begin
            state_q  <= S_N1;
          end
        end
        S_N1: if (alu_rsp.done) begin
          t_q     <= alu_rsp.res;
          state_q <= S_N2;
        end
        S_N2: if (alu_rsp.done) begin
          num_q   <= {diff_tr[W-17:0], 16'h0};
          state_q <= S_SLOPE;
        end
        S_SLOPE: if (alu_rsp.done) begin
          slope_q[plane_q] <= sat_s32(alu_rsp.res);
          state_q          <= S_I1;
        end
        S_I1: if (alu_rsp.done) begin
          t_q     <= alu_rsp.res;
          state_q <= S_I2;
        end
        S_I2: if (alu_rsp.done) begin
          num_q   <= diff_tr;
          state_q <= S_ICPT;
        end
        S_ICPT: if (alu_rsp.done) begin
          icpt_q[plane_q] <= sat_s32(alu_rsp.res);
          sum_q           <= '0;
          i_q             <= '0;
          state_q         <= S_RMUL;
        end
        S_RMUL: if (alu_rsp.done) begin
          r_q     <= r_new;
          state_q <= S_RSQ;
        end
        S_RSQ: if (alu_rsp.done) begin
          t_q     <= alu_rsp.res;
          state_q <= S_RDIV;
        end
        S_RDIV: if (alu_rsp.done) begin
          sum_q <= sum_q + alu_rsp.res;
          if (last_i) begin
            state_q <= S_CHI;
          end else begin
            i_q     <= i_q + IW'(1);
            state_q <= S_RMUL;
          end
        end
        S_CHI: if (alu_rsp.done) begin
          chi_q[plane_q] <= sat_u32(alu_rsp.res);
          if (!plane_q) begin
            plane_q <= 1'b1;
            i_q     <= '0;
            s0_q <= '0; sy_q <= '0; syy_q <= '0; sc_q <= '0; scy_q <= '0;
            state_q <= S_ROOT;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || fit_o.ready) begin
            if (status_q == wlf_pkg::STAT_OK) begin
              o_sxy_q <= slope_q[0]; o_ixy_q <= icpt_q[0]; o_cxy_q <= chi_q[0];
              o_szy_q <= slope_q[1]; o_izy_q <= icpt_q[1]; o_czy_q <= chi_q[1];
            end else begin
              o_sxy_q <= '0; o_ixy_q <= '0; o_cxy_q <= '0;
              o_szy_q <= '0; o_izy_q <= '0; o_czy_q <= '0;
            end
            o_stat_q    <= status_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign pnt_i.ready        = state_q == S_IDLE;
  assign fit_o.valid        = out_valid_q;
  assign fit_o.slope_xy     = o_sxy_q;
  assign fit_o.intercept_xy = o_ixy_q;
  assign fit_o.chi_xy       = o_cxy_q;
  assign fit_o.slope_zy     = o_szy_q;
  assign fit_o.intercept_zy = o_izy_q;
  assign fit_o.chi_zy       = o_czy_q;
  assign fit_o.fit_status   = o_stat_q;

endmodule

/* rtl/wlf_chk.sv */
module wlf_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] slope_xy_i,
  input logic [31:0] intercept_xy_i,
  input logic [31:0] chi_xy_i,
  input logic [31:0] slope_zy_i,
  input logic [31:0] intercept_zy_i,
  input logic [31:0] chi_zy_i,
  input logic [1:0]  fit_status_i
);

  // stalled result holds valid, slope_xy, chi_zy and fit_status
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(slope_xy_i) &&
      $stable(chi_zy_i) && $stable(fit_status_i))
    else $error("result changed under stall");

  // failed fits carry zero payload
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (fit_status_i != wlf_pkg::STAT_OK) |->
      slope_xy_i == 32'd0 && intercept_xy_i == 32'd0 && chi_xy_i == 32'd0 &&
      slope_zy_i == 32'd0 && intercept_zy_i == 32'd0 && chi_zy_i == 32'd0)
    else $error("nonzero payload on failed fit");

  // closing a track blocks new hits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("ready right after track close");

  // a fresh result never follows a request in the very next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("result too early");

endmodule

bind weighted_line_fit_chi2_core wlf_chk u_wlf_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (pnt_i.valid),
  .in_ready_i     (pnt_i.ready),
  .in_last_i      (pnt_i.last_point),
  .out_valid_i    (fit_o.valid),
  .out_ready_i    (fit_o.ready),
  .slope_xy_i     (fit_o.slope_xy),
  .intercept_xy_i (fit_o.intercept_xy),
  .chi_xy_i       (fit_o.chi_xy),
  .slope_zy_i     (fit_o.slope_zy),
  .intercept_zy_i (fit_o.intercept_zy),
  .chi_zy_i       (fit_o.chi_zy),
  .fit_status_i   (fit_o.fit_status)
);

/* verif/tb_weighted_line_fit_chi2_core.sv */
`timescale 1ns / 1ps

module tb_weighted_line_fit_chi2_core;

  typedef struct {
    logic [31:0] px, py, pz, sx, sz, ex, ez;
    logic        last;
    bit          drain;   // hold until all fits are back
  } hit_t;

  typedef struct {
    logic [31:0] slope_xy, intercept_xy, chi_xy, slope_zy, intercept_zy, chi_zy;
    logic [1:0]  status;
  } fit_t;

  typedef logic signed [255:0] big_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wlf_pnt_if pnt ();
  wlf_fit_if fit ();

  weighted_line_fit_chi2_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pnt_i (pnt.sink),
    .fit_o (fit.source)
  );

  always #4 clk_i = ~clk_i;

  hit_t hit_q[$];
  fit_t fit_exp_q[$];
  int   err_cnt = 0;
  bit   stim_done = 0;

  // track store of the predictor
  logic [31:0] trk_x[wlf_pkg::MAX_POINTS], trk_y[wlf_pkg::MAX_POINTS];
  logic [31:0] trk_z[wlf_pkg::MAX_POINTS];
  logic [31:0] trk_sx[wlf_pkg::MAX_POINTS], trk_sz[wlf_pkg::MAX_POINTS];
  logic [31:0] trk_ex[wlf_pkg::MAX_POINTS], trk_ez[wlf_pkg::MAX_POINTS];
  int          trk_cnt = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic big_t sat_s32(big_t q);
    if (q > big_t'(64'sd2147483647)) return big_t'(64'sd2147483647);
    if (q < -big_t'(64'sd2147483648)) return -big_t'(64'sd2147483648);
    return q;
  endfunction

  // zplane selects z against y, else x against y
  function automatic bit line_fit(bit zplane, int m, output logic [31:0] slope,
                                  output logic [31:0] icpt, output logic [31:0] chi);
    big_t s0, sy, syy, sc, scy, w, yv, cv, d, num, q, sum, t, ev;
    longint sl, ic, pred, r;
    logic [31:0] cc, ss, ee;
    s0 = 0; sy = 0; syy = 0; sc = 0; scy = 0; sum = 0;
    slope = 0; icpt = 0; chi = 0;
    for (int i = 0; i < m; i++) begin
      ss  = zplane ? trk_sz[i] : trk_sx[i];
      cc  = zplane ? trk_z[i] : trk_x[i];
      w   = $signed({192'd0, 64'd2 * int_sqrt({16'd0, ss, 16'd0})});
      yv  = $signed(trk_y[i]);
      cv  = $signed(cc);
      s0  = s0 + w;
      sy  = sy + w * yv;
      syy = syy + w * yv * yv;
      sc  = sc + w * cv;
      scy = scy + w * yv * cv;
    end
    d = s0 * syy - sy * sy;
    if (d == 0) return 0;
    num = (s0 * scy - sy * sc) * big_t'(65536);
    q   = sat_s32(num / d);
    sl  = longint'(q);
    num = syy * sc - sy * scy;
    q   = sat_s32(num / d);
    ic  = longint'(q);
    for (int i = 0; i < m; i++) begin
      cc   = zplane ? trk_z[i] : trk_x[i];
      ee   = zplane ? trk_ez[i] : trk_ex[i];
      if (ee == 0) ee = 1;
      pred = (sl * longint'($signed(trk_y[i]))) / 65536 + ic;
      r    = longint'($signed(cc)) - pred;
      t    = big_t'(r);
      ev   = $signed({224'd0, ee});
      sum  = sum + (t * t) / ev;
    end
    q     = sum / big_t'(m - 2);
    slope = sl[31:0];
    icpt  = ic[31:0];
    chi   = (q > big_t'(64'hFFFF_FFFF)) ? 32'hFFFF_FFFF : q[31:0];
    return 1;
  endfunction

  task automatic predict_fit(hit_t h);
    fit_t f;
    bit   okx, okz;
    int   m;
    if (trk_cnt < wlf_pkg::MAX_POINTS) begin
      trk_x[trk_cnt] = h.px;  trk_y[trk_cnt] = h.py;  trk_z[trk_cnt] = h.pz;
      trk_sx[trk_cnt] = h.sx; trk_sz[trk_cnt] = h.sz;
      trk_ex[trk_cnt] = h.ex; trk_ez[trk_cnt] = h.ez;
      trk_cnt++;
    end
    if (!h.last) return;
    m = trk_cnt;
    trk_cnt = 0;
    f = '{default: '0};
    if (m < 3) begin
      f.status = wlf_pkg::STAT_FEW;
    end else begin
      okx = line_fit(0, m, f.slope_xy, f.intercept_xy, f.chi_xy);
      okz = line_fit(1, m, f.slope_zy, f.intercept_zy, f.chi_zy);
      if (!okx || !okz) begin
        f = '{default: '0};
        f.status = wlf_pkg::STAT_SING;
      end else begin
        f.status = wlf_pkg::STAT_OK;
      end
    end
    fit_exp_q = {fit_exp_q, f};
  endtask

  // driver
  int  src_idle = 0;
  hit_t cur;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pnt.valid && pnt.ready) begin
        predict_fit(cur);
        void'(hit_q.pop_front());
      end
      if (src_idle > 0) src_idle <= src_idle - 1;
      if (pnt.valid && !pnt.ready) begin
        // keep offering the same request
      end else if (hit_q.size() > 0 && src_idle == 0 &&
                   !(hit_q[0].drain && fit_exp_q.size() != 0)) begin
        if (hit_q.size() > 60 && $urandom_range(0, 9) == 0) begin
          src_idle <= $urandom_range(1, 18);
          pnt.valid <= 1'b0;
        end else begin
          cur = hit_q[0];
          pnt.valid      <= 1'b1;
          pnt.pos_x      <= cur.px;
          pnt.pos_y      <= cur.py;
          pnt.pos_z      <= cur.pz;
          pnt.size_x     <= cur.sx;
          pnt.size_z     <= cur.sz;
          pnt.error_x    <= cur.ex;
          pnt.error_z    <= cur.ez;
          pnt.last_point <= cur.last;
        end
      end else begin
        pnt.valid <= 1'b0;
      end
    end
  end

  // long hold-off of the receiver at the start, so the block backs up
  int hold_cnt = 40000;
  always @(posedge clk_i) if (rst_ni && hold_cnt > 0) hold_cnt <= hold_cnt - 1;

  // monitor
  int   snk_idle = 0;
  fit_t exp_f;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (fit.valid && fit.ready) begin
        if (fit_exp_q.size() == 0) begin
          $error("fit result with no request pending");
          err_cnt++;
        end else begin
          exp_f = fit_exp_q.pop_front();
          if (fit.slope_xy !== exp_f.slope_xy) begin
            $error("slope_xy exp %h got %h", exp_f.slope_xy, fit.slope_xy); err_cnt++;
          end
          if (fit.intercept_xy !== exp_f.intercept_xy) begin
            $error("intercept_xy exp %h got %h", exp_f.intercept_xy, fit.intercept_xy);
            err_cnt++;
          end
          if (fit.chi_xy !== exp_f.chi_xy) begin
            $error("chi_xy exp %h got %h", exp_f.chi_xy, fit.chi_xy); err_cnt++;
          end
          if (fit.slope_zy !== exp_f.slope_zy) begin
            $error("slope_zy exp %h got %h", exp_f.slope_zy, fit.slope_zy); err_cnt++;
          end
          if (fit.intercept_zy !== exp_f.intercept_zy) begin
            $error("intercept_zy exp %h got %h", exp_f.intercept_zy, fit.intercept_zy);
            err_cnt++;
          end
          if (fit.chi_zy !== exp_f.chi_zy) begin
            $error("chi_zy exp %h got %h", exp_f.chi_zy, fit.chi_zy); err_cnt++;
          end
          if (fit.fit_status !== exp_f.status) begin
            $error("fit_status exp %0d got %0d", exp_f.status, fit.fit_status); err_cnt++;
          end
        end
      end
      if (hold_cnt > 1) begin
        fit.ready <= 1'b0;
      end else if (snk_idle > 0) begin
        snk_idle  <= snk_idle - 1;
        fit.ready <= 1'b0;
      end else if (hit_q.size() > 60 && $urandom_range(0, 7) == 0) begin
        snk_idle  <= $urandom_range(1, 18);
        fit.ready <= 1'b0;
      end else begin
        fit.ready <= 1'b1;
      end
    end
  end

  function automatic hit_t mk_hit(logic [31:0] px, py, pz, sx, sz, ex, ez, bit last);
    hit_t h;
    h.px = px; h.py = py; h.pz = pz; h.sx = sx; h.sz = sz; h.ex = ex; h.ez = ez;
    h.last = last; h.drain = 0;
    return h;
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
    endcase
  endfunction

  function automatic logic [31:0] rnd_size();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 0;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  function automatic logic [31:0] rnd_err();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
    endcase
  endfunction

  task automatic add_track(int n);
    for (int i = 0; i < n; i++)
      hit_q = {hit_q, mk_hit(rnd_coord(), rnd_coord(), rnd_coord(), rnd_size(), rnd_size(),
                             rnd_err(), rnd_err(), i == n - 1)};
  endtask

  int   n_items;
  hit_t h;
  initial begin
    pnt.valid = 0; pnt.pos_x = 0; pnt.pos_y = 0; pnt.pos_z = 0; pnt.size_x = 0;
    pnt.size_z = 0; pnt.error_x = 0; pnt.error_z = 0; pnt.last_point = 0;
    fit.ready = 0;

    // directed: one and two point tracks
    hit_q = {hit_q, mk_hit(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0,
                           32'h1, 32'hFFFF_FFFF, 1)};
    hit_q = {hit_q, mk_hit(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000,
                           32'h1_0000, 32'h1_0000, 0)};
    hit_q = {hit_q, mk_hit(32'h2_0000, 32'h2_0000, 32'h2_0000, 32'h1_0000, 32'h1_0000,
                           32'h1_0000, 32'h1_0000, 1)};
    // singular: zero weights
    for (int i = 0; i < 3; i++)
      hit_q = {hit_q, mk_hit(i * 32'h1_0000, i * 32'h3_0000, 32'h5, 0, 0, 1, 1, i == 2)};
    // singular: all at one y
    for (int i = 0; i < 3; i++)
      hit_q = {hit_q, mk_hit(i * 32'h1_0000, 32'h4_0000, i, 32'h1_0000, 32'h2_0000, 1, 1,
                             i == 2)};
    // clean line with zero error, then buffer overflow with extreme values
    for (int i = 0; i < 4; i++)
      hit_q = {hit_q, mk_hit(32'h1_0000 + i * 32'h2_0000, i * 32'h1_0000,
                             32'hFFFF_0000 - i, 32'h4_0000, 32'h1_0000, 0, 0, i == 3)};
    for (int i = 0; i < 6; i++)
      hit_q = {hit_q, mk_hit(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                             i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                             i[1] ? 32'h7FFF_FFFF : 32'h8000_0000,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, i == 5)};
    // random, mostly well-formed tracks of short length
    n_items = hit_q.size();
    while (n_items < 600) begin
      if ($urandom_range(0, 9) == 0) begin
        h = mk_hit($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 1));
        hit_q = {hit_q, h};
        n_items++;
      end else begin
        int n;
        case ($urandom_range(0, 9))
          0, 1, 2: n = $urandom_range(1, 2);
          3, 4, 5, 6: n = 3;
          7, 8: n = 4;
          default: n = $urandom_range(5, 6);
        endcase
        if ($urandom_range(0, 49) == 0) begin
          add_track(n);
          hit_q[hit_q.size() - n].drain = 1;
        end else begin
          add_track(n);
        end
        n_items += n;
      end
    end
    hit_q[hit_q.size() / 2].drain = 1;
    // close any open track
    hit_q = {hit_q, mk_hit($urandom, $urandom, $urandom, $urandom, $urandom, 1, 1, 1)};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (hit_q.size() == 0 && fit_exp_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && fit_exp_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #400ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* weighted_line_fit_chi2_core.f */
rtl/wlf_pkg.sv
rtl/wlf_if.sv
rtl/wlf_alu.sv
rtl/weighted_line_fit_chi2_core.sv
rtl/wlf_chk.sv
verif/tb_weighted_line_fit_chi2_core.sv
